// ----- design/scfs_pkg.sv -----
package scfs_pkg;

	// timer and register widths
	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int BYTE_W      = 8;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
	typedef logic [BYTE_W-1:0]      byte_t;

	// frame characters
	localparam byte_t CH_S    = 8'h73;
	localparam byte_t CH_C    = 8'h63;
	localparam byte_t CH_R    = 8'h72;
	localparam byte_t CH_CR   = 8'h0d;
	localparam byte_t CH_B    = 8'h62;
	localparam byte_t CH_ZERO = 8'h30;
	localparam byte_t CH_FOUR = 8'h34;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACK_DELAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALVE_OPEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_RUN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN    = 2'd3;

	// register reset values
	localparam cfg_word_t RST_ACK_DELAY  = 16'd10;
	localparam cfg_word_t RST_VALVE_OPEN = 16'd12000;
	localparam cfg_word_t RST_FAN_RUN    = 16'd5000;
	localparam logic      RST_LOOP_EN    = 1'b1;

	// classified request handed from front to back
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_START = 2'd2,
		OP_ABORT = 2'd3
	} op_t;

	// one result word
	typedef struct packed {
		logic busy;
		logic send_ack;
		logic valve_on;
		logic fan_on;
	} res_t;

endpackage

// ----- design/scfs_front.sv -----
module scfs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_tick,
	input  scfs_pkg::byte_t       in_byte,
	input  logic                  q_ready,
	output logic                  in_ready,
	output logic                  push,
	output scfs_pkg::op_t         push_op
);

	logic [2:0]      pos_q, pos_d;
	scfs_pkg::byte_t c0_q, c1_q, c2_q;
	scfs_pkg::byte_t c0_d, c1_d, c2_d;
	logic            take;

	assign in_ready = q_ready;
	assign take     = in_valid && q_ready;
	assign push     = take;

	// frame parser: position counter and command characters
	always_comb begin
		pos_d   = pos_q;
		c0_d    = c0_q;
		c1_d    = c1_q;
		c2_d    = c2_q;
		push_op = scfs_pkg::OP_NONE;
		if (in_tick) begin
			push_op = scfs_pkg::OP_TICK;
		end else begin
			case (pos_q)
				3'd1: pos_d = (in_byte == scfs_pkg::CH_C) ? 3'd2 : 3'd0;
				3'd2: pos_d = (in_byte == scfs_pkg::CH_R) ? 3'd3 : 3'd0;
				3'd3: begin
					c0_d  = in_byte;
					pos_d = 3'd4;
				end
				3'd4: begin
					c1_d  = in_byte;
					pos_d = 3'd5;
				end
				3'd5: begin
					if (c0_q == scfs_pkg::CH_B && c1_q == scfs_pkg::CH_FOUR &&
					    in_byte == scfs_pkg::CH_ZERO) begin
						push_op = scfs_pkg::OP_ABORT;
						pos_d   = 3'd0;
					end else begin
						c2_d  = in_byte;
						pos_d = 3'd6;
					end
				end
				3'd6: begin
					// noise before the terminator is ignored
					if (in_byte == scfs_pkg::CH_CR) begin
						pos_d = 3'd0;
						if (c0_q == scfs_pkg::CH_B && c1_q == scfs_pkg::CH_ZERO &&
						    c2_q == scfs_pkg::CH_ZERO) begin
							push_op = scfs_pkg::OP_START;
						end
					end
				end
				default: pos_d = (in_byte == scfs_pkg::CH_S) ? 3'd1 : 3'd0;
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
			c0_q  <= '0;
			c1_q  <= '0;
			c2_q  <= '0;
		end else if (take) begin
			pos_q <= pos_d;
			c0_q  <= c0_d;
			c1_q  <= c1_d;
			c2_q  <= c2_d;
		end
	end

endmodule

// ----- design/scfs_queue.sv -----
module scfs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  scfs_pkg::op_t push_op,
	input  logic          pop,
	output logic          not_full,
	output logic          not_empty,
	output scfs_pkg::op_t head_op
);

	scfs_pkg::op_t                   mem_q [scfs_pkg::QUEUE_DEPTH];
	logic [scfs_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [scfs_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push, do_pop;

	assign not_full  = (count_q != scfs_pkg::QCNT_W'(scfs_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head_op   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == scfs_pkg::QPTR_W'(scfs_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == scfs_pkg::QPTR_W'(scfs_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/scfs_back.sv -----
module scfs_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [scfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  scfs_pkg::cfg_word_t                  cfg_wdata,
	input  logic                                 q_valid,
	input  scfs_pkg::op_t                        q_op,
	output logic                                 q_pop,
	input  logic                                 out_ready,
	output logic                                 res_valid,
	output scfs_pkg::res_t                       res
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ACK   = 2'd1,
		PH_VALVE = 2'd2,
		PH_FAN   = 2'd3
	} phase_t;

	scfs_pkg::cfg_word_t ack_delay_q, valve_open_q, fan_run_q;
	logic                loop_en_q;

	phase_t              phase_q, phase_d;
	scfs_pkg::timer_t    timer_q, timer_d, timer_dec;
	logic                fan_q, fan_d, valve_q, valve_d, ack_d;
	logic                res_valid_q;
	scfs_pkg::res_t      res_q;

	assign q_pop     = q_valid && (!res_valid_q || out_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_delay_q  <= scfs_pkg::RST_ACK_DELAY;
			valve_open_q <= scfs_pkg::RST_VALVE_OPEN;
			fan_run_q    <= scfs_pkg::RST_FAN_RUN;
			loop_en_q    <= scfs_pkg::RST_LOOP_EN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scfs_pkg::REG_ACK_DELAY:  ack_delay_q  <= cfg_wdata;
				scfs_pkg::REG_VALVE_OPEN: valve_open_q <= cfg_wdata;
				scfs_pkg::REG_FAN_RUN:    fan_run_q    <= cfg_wdata;
				scfs_pkg::REG_LOOP_EN:    loop_en_q    <= cfg_wdata[0];
				default:                  ;
			endcase
		end
	end

	assign timer_dec = (timer_q != '0) ? timer_q - 1'b1 : '0;

	// sequencer next state
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		fan_d   = fan_q;
		valve_d = valve_q;
		ack_d   = 1'b0;
		unique case (q_op)
			scfs_pkg::OP_START: begin
				if (phase_q == PH_IDLE) begin
					ack_d   = 1'b1;
					phase_d = PH_ACK;
					timer_d = scfs_pkg::timer_t'(ack_delay_q);
				end
			end
			scfs_pkg::OP_ABORT: begin
				fan_d   = 1'b0;
				valve_d = 1'b0;
			end
			scfs_pkg::OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					timer_d = timer_dec;
					if (timer_dec == '0) begin
						unique case (phase_q)
							PH_ACK: begin
								if (loop_en_q) begin
									valve_d = 1'b1;
									phase_d = PH_VALVE;
									timer_d = scfs_pkg::timer_t'(valve_open_q);
								end else begin
									phase_d = PH_IDLE;
								end
							end
							PH_VALVE: begin
								fan_d   = 1'b1;
								phase_d = PH_FAN;
								timer_d = scfs_pkg::timer_t'(fan_run_q);
							end
							PH_FAN: begin
								fan_d   = 1'b0;
								valve_d = 1'b0;
								phase_d = PH_IDLE;
							end
							default: phase_d = PH_IDLE;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			fan_q       <= 1'b0;
			valve_q     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (q_pop) begin
				phase_q        <= phase_d;
				timer_q        <= timer_d;
				fan_q          <= fan_d;
				valve_q        <= valve_d;
				res_valid_q    <= 1'b1;
				res_q.fan_on   <= fan_d;
				res_q.valve_on <= valve_d;
				res_q.send_ack <= ack_d;
				res_q.busy     <= (phase_d != PH_IDLE);
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// an acknowledge always starts a running sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.send_ack) |-> res_q.busy)
		else $error("send_ack without busy");

	// the fan only runs in the fan phase
	assert property (@(posedge clk) disable iff (!arst_n)
		fan_q |-> (phase_q == PH_FAN))
		else $error("fan on outside fan phase");

	// no request is taken while a result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !out_ready) |-> !q_pop)
		else $error("request popped over a stalled result");

endmodule

// ----- design/serial_command_frame_sequencer.sv -----
// Serial command frame sequencer. Each request is a received byte (tuser 0) or a
// millisecond tick (tuser 1); every request yields exactly one result with the fan,
// valve, acknowledge and busy levels after it. A front parser matches the frame
// "scr" + three command characters + CR and classifies each request; a two-entry
// queue hands the classified requests to the sequencer, which runs the acknowledge,
// valve and fan timers and registers the result. One request is taken every clock
// cycle while the queue has room, which m_tready back-pressure can take away; each
// accepted request passes through the queue and sequencer into the result register.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while no request is in flight, the block does not enforce it.
module serial_command_frame_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [scfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  scfs_pkg::cfg_word_t            cfg_wdata,
	// request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
	input  logic                           s_tuser,  // [0] req_type
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata   // [0] fan_on, [1] valve_on,
	                                                 // [2] send_ack, [3] busy_res, [7:4] zero
);

	logic           push, q_not_full, q_not_empty, q_pop;
	scfs_pkg::op_t  push_op, head_op;
	scfs_pkg::res_t res;

	// request parsing and classification
	scfs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_tick  (s_tuser),
		.in_byte  (s_tdata),
		.q_ready  (q_not_full),
		.in_ready (s_tready),
		.push     (push),
		.push_op  (push_op)
	);

	// queue between parser and sequencer
	scfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (q_pop),
		.not_full  (q_not_full),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	// timed sequencer and result register
	scfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_not_empty),
		.q_op      (head_op),
		.q_pop     (q_pop),
		.out_ready (m_tready),
		.res_valid (m_tvalid),
		.res       (res)
	);

	assign m_tdata = {4'b0000, res};

endmodule

// ----- tb/tb_serial_command_frame_sequencer.sv -----
module tb_serial_command_frame_sequencer;
	import scfs_pkg::*;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;
	localparam int N_PHASES      = 7;
	localparam int PHASE_REQS    = 150;
	localparam int DIR_ROWS      = 22;
	localparam int DIR_SETUP_ROW = 2;
	localparam int PRESSURE_LEN  = 80;
	localparam int TAIL_CYCLES   = 8;
	localparam int CYCLE_LIMIT   = 200000;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ACK   = 3'd1,
		PH_VALVE = 3'd2,
		PH_FAN   = 3'd3
	} seq_phase_t;

	// one directed row: request, and typed levels where they are obvious
	typedef struct packed {
		logic  is_tick;
		byte_t data;
		logic  typed;
		res_t  levels;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	cfg_word_t            cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [7:0] rx_byte
	logic                 s_tuser;   // [0] req_type
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // [0] fan_on, [1] valve_on, [2] send_ack, [3] busy_res

	// shadow registers and sequencer state
	cfg_word_t  ack_dly   = RST_ACK_DELAY;
	cfg_word_t  valve_dly = RST_VALVE_OPEN;
	cfg_word_t  fan_dly   = RST_FAN_RUN;
	logic       loop_en   = RST_LOOP_EN;
	logic [2:0] frm_pos   = 3'd0;
	byte_t      cmd_ch [3] = '{8'h00, 8'h00, 8'h00};
	seq_phase_t seq_ph    = PH_IDLE;
	timer_t     tmr       = '0;
	logic       fan_lvl   = 1'b0;
	logic       valve_lvl = 1'b0;

	logic [CFG_IDX_W-1:0] reg_ids [4] = '{REG_ACK_DELAY, REG_VALVE_OPEN, REG_FAN_RUN, REG_LOOP_EN};

	res_t     res_due_q [$];
	logic     req_tick_q [$];
	byte_t    req_byte_q [$];
	dir_row_t dir_tab [DIR_ROWS];
	res_t     want, got;
	int       err_cnt     = 0;
	int       cyc_cnt     = 0;
	int       hold_cnt    = 0;
	bit       idle_on     = 1'b1;
	bit       calm        = 1'b0;
	bit       pressure_go = 1'b0;
	bit       pressure_done = 1'b0;

	serial_command_frame_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// levels after one request; updates the shadow state
	function automatic res_t next_levels(input logic is_tick, input byte_t b);
		res_t r;
		logic ack;
		ack = 1'b0;
		if (!is_tick) begin
			case (frm_pos)
				3'd1: frm_pos = (b == CH_C) ? 3'd2 : 3'd0;
				3'd2: frm_pos = (b == CH_R) ? 3'd3 : 3'd0;
				3'd3: begin
					cmd_ch[0] = b;
					frm_pos = 3'd4;
				end
				3'd4: begin
					cmd_ch[1] = b;
					frm_pos = 3'd5;
				end
				3'd5: begin
					// "b40" forces everything off right away
					if (cmd_ch[0] == CH_B && cmd_ch[1] == CH_FOUR && b == CH_ZERO) begin
						fan_lvl = 1'b0;
						valve_lvl = 1'b0;
						frm_pos = 3'd0;
					end else begin
						cmd_ch[2] = b;
						frm_pos = 3'd6;
					end
				end
				3'd6: begin
					// only CR closes the frame, anything else is dropped
					if (b == CH_CR) begin
						frm_pos = 3'd0;
						if (seq_ph == PH_IDLE && cmd_ch[0] == CH_B && cmd_ch[1] == CH_ZERO &&
							cmd_ch[2] == CH_ZERO) begin
							ack = 1'b1;
							seq_ph = PH_ACK;
							tmr = timer_t'(ack_dly);
						end
					end
				end
				default: frm_pos = (b == CH_S) ? 3'd1 : 3'd0;
			endcase
		end else if (seq_ph != PH_IDLE) begin
			// zero-length phase ends on the first tick
			if (tmr != '0)
				tmr = tmr - 1'b1;
			if (tmr == '0) begin
				case (seq_ph)
					PH_ACK: begin
						if (loop_en) begin
							valve_lvl = 1'b1;
							seq_ph = PH_VALVE;
							tmr = timer_t'(valve_dly);
						end else begin
							seq_ph = PH_IDLE;
						end
					end
					PH_VALVE: begin
						fan_lvl = 1'b1;
						seq_ph = PH_FAN;
						tmr = timer_t'(fan_dly);
					end
					default: begin
						fan_lvl = 1'b0;
						valve_lvl = 1'b0;
						seq_ph = PH_IDLE;
					end
				endcase
			end
		end
		r.fan_on = fan_lvl;
		r.valve_on = valve_lvl;
		r.send_ack = ack;
		r.busy = (seq_ph != PH_IDLE);
		return r;
	endfunction

	// stimulus builders
	function automatic void add_req(input logic is_tick, input byte_t data);
		req_tick_q.push_back(is_tick);
		req_byte_q.push_back(data);
	endfunction

	function automatic void add_ticks(input int n);
		repeat (n) add_req(REQ_TICK, byte_t'($urandom_range(0, 255)));
	endfunction

	// a byte, sometimes with a tick slipped in ahead of it
	function automatic void add_byte(input byte_t data);
		if ($urandom_range(0, 9) == 0)
			add_ticks(1);
		add_req(REQ_BYTE, data);
	endfunction

	function automatic byte_t pick_cmd();
		case ($urandom_range(0, 3))
			0: return CH_B;
			1: return CH_ZERO;
			2: return CH_FOUR;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_frame(input byte_t c0, input byte_t c1, input byte_t c2,
		input logic close);
		add_byte(CH_S);
		add_byte(CH_C);
		add_byte(CH_R);
		add_byte(c0);
		add_byte(c1);
		add_byte(c2);
		if (close) begin
			if ($urandom_range(0, 9) == 0)
				add_byte(byte_t'($urandom_range(0, 255)));
			add_byte(CH_CR);
		end
	endfunction

	// mostly well-formed frames with random content, some noise and cut frames
	task automatic build_phase(input int target);
		int sel;
		byte_t pfx [6];
		pfx = '{CH_S, CH_C, CH_R, CH_B, CH_ZERO, CH_ZERO};
		while (req_tick_q.size() < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				add_frame(CH_B, CH_ZERO, CH_ZERO, 1'b1);
				add_ticks($urandom_range(0, 12));
			end else if (sel < 52) begin
				add_frame(CH_B, CH_FOUR, CH_ZERO, 1'b0);
			end else if (sel < 60) begin
				add_frame(CH_B, CH_FOUR, pick_cmd(), 1'b1);
			end else if (sel < 70) begin
				add_frame(pick_cmd(), pick_cmd(), pick_cmd(), 1'b1);
			end else if (sel < 80) begin
				for (int i = 0; i < $urandom_range(1, 6); i++)
					add_byte(pfx[i]);
				add_byte(byte_t'($urandom_range(0, 255)));
			end else if (sel < 90) begin
				add_ticks($urandom_range(1, 20));
			end else begin
				repeat ($urandom_range(1, 4)) add_req(REQ_BYTE, byte_t'($urandom_range(0, 255)));
			end
		end
	endtask

	// offer one request, wait for the handshake, record the levels due
	task automatic send_req(input logic is_tick, input byte_t data, input logic typed,
		input res_t typed_levels);
		res_t lv;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= is_tick;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		lv = next_levels(is_tick, data);
		res_due_q.push_back(typed ? typed_levels : lv);
	endtask

	task automatic drain();
		while (res_due_q.size() != 0) @(posedge clk);
	endtask

	// write all four registers back to back, block drained
	task automatic apply_setting(input cfg_word_t a, input cfg_word_t v, input cfg_word_t f,
		input cfg_word_t l);
		cfg_word_t vals [4];
		vals = '{a, v, f, l};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_ids[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			case (reg_ids[i])
				REG_ACK_DELAY:  ack_dly = vals[i];
				REG_VALVE_OPEN: valve_dly = vals[i];
				REG_FAN_RUN:    fan_dly = vals[i];
				REG_LOOP_EN:    loop_en = vals[i][0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// loop flag with junk in the upper bits half of the time
	function automatic cfg_word_t loop_word(input logic on);
		if ($urandom_range(0, 1) == 0)
			return cfg_word_t'(on);
		return cfg_word_t'(($urandom_range(0, 32767) << 1) | on);
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (res_due_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("result with nothing pending: %h", m_tdata);
			end else begin
				want = res_due_q.pop_front();
				got = res_t'(m_tdata[3:0]);
				if (got.fan_on !== want.fan_on || got.valve_on !== want.valve_on ||
					got.send_ack !== want.send_ack || got.busy !== want.busy ||
					m_tdata[7:4] !== 4'h0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: exp fan %b valve %b ack %b busy %b, got fan %b valve %b ack %b busy %b pad %h",
							want.fan_on, want.valve_on, want.send_ack, want.busy,
							got.fan_on, got.valve_on, got.send_ack, got.busy, m_tdata[7:4]);
				end
			end
		end
	end

	// result side back-pressure, one long hold-off when asked
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (pressure_go && !pressure_done) begin
				pressure_done = 1'b1;
				hold_cnt = PRESSURE_LEN - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				hold_cnt = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		cfg_word_t ph_ack [N_PHASES];
		cfg_word_t ph_valve [N_PHASES];
		cfg_word_t ph_fan [N_PHASES];
		logic      ph_loop [N_PHASES];

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ACK_DELAY;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tuser <= REQ_BYTE;
		s_tdata <= 8'h00;

		// levels columns: busy ack valve fan
		dir_tab = '{
			'{REQ_TICK, 8'h00, 1'b1, 4'b0000},  // tick straight after reset
			'{REQ_BYTE, 8'hff, 1'b1, 4'b0000},  // stray byte
			'{REQ_BYTE, CH_S,  1'b0, 4'b0000},
			'{REQ_BYTE, 8'h78, 1'b0, 4'b0000},  // broken prefix
			'{REQ_BYTE, CH_S,  1'b0, 4'b0000},
			'{REQ_BYTE, CH_C,  1'b0, 4'b0000},
			'{REQ_BYTE, CH_R,  1'b0, 4'b0000},
			'{REQ_BYTE, CH_B,  1'b0, 4'b0000},
			'{REQ_BYTE, CH_ZERO, 1'b0, 4'b0000},
			'{REQ_BYTE, CH_ZERO, 1'b0, 4'b0000},
			'{REQ_BYTE, 8'hff, 1'b0, 4'b0000},  // noise before CR is dropped
			'{REQ_BYTE, CH_CR, 1'b1, 4'b1100},  // start: ack pulse, busy
			'{REQ_TICK, 8'h00, 1'b1, 4'b1010},  // zero delay: valve opens
			'{REQ_TICK, 8'hff, 1'b1, 4'b1011},  // fan on
			'{REQ_BYTE, CH_S,  1'b0, 4'b0000},
			'{REQ_BYTE, CH_C,  1'b0, 4'b0000},
			'{REQ_BYTE, CH_R,  1'b0, 4'b0000},
			'{REQ_BYTE, CH_B,  1'b0, 4'b0000},
			'{REQ_BYTE, CH_FOUR, 1'b0, 4'b0000},
			'{REQ_BYTE, CH_ZERO, 1'b1, 4'b1000},  // abort: off, still busy
			'{REQ_TICK, 8'h00, 1'b1, 4'b0000},  // fan step finishes the run
			'{REQ_TICK, 8'hff, 1'b1, 4'b0000}
		};

		// register settings per phase: minimum, loop off, mixed, random, maximum
		ph_ack   = '{16'd0, 16'd3, 16'd1, 16'd0, 16'd0, 16'd2, 16'hffff};
		ph_valve = '{16'd0, 16'd5, 16'd2, 16'd0, 16'd0, 16'd1, 16'hffff};
		ph_fan   = '{16'd0, 16'd4, 16'd3, 16'd0, 16'd0, 16'd6, 16'hffff};
		ph_loop  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
		for (int p = 3; p <= 4; p++) begin
			ph_ack[p] = cfg_word_t'($urandom_range(0, 10));
			ph_valve[p] = cfg_word_t'($urandom_range(0, 10));
			ph_fan[p] = cfg_word_t'($urandom_range(0, 10));
		end
		ph_loop[3] = 1'($urandom_range(0, 1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_SETUP_ROW) begin
				s_tvalid <= 1'b0;
				drain();
				apply_setting(16'd0, 16'd0, 16'd0, loop_word(1'b1));
			end
			send_req(dir_tab[i].is_tick, dir_tab[i].data, dir_tab[i].typed, dir_tab[i].levels);
		end
		s_tvalid <= 1'b0;
		drain();

		// random phases
		for (int p = 0; p < N_PHASES; p++) begin
			apply_setting(ph_ack[p], ph_valve[p], ph_fan[p], loop_word(ph_loop[p]));
			build_phase(PHASE_REQS);
			if (p == 1)
				pressure_go = 1'b1;
			if (p == N_PHASES - 1) begin
				calm = 1'b1;
				idle_on = 1'b0;
			end
			while (req_tick_q.size() != 0)
				send_req(req_tick_q.pop_front(), req_byte_q.pop_front(), 1'b0, 4'b0000);
			s_tvalid <= 1'b0;
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && res_due_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- serial_command_frame_sequencer.f -----
design/scfs_pkg.sv
design/scfs_front.sv
design/scfs_queue.sv
design/scfs_back.sv
design/serial_command_frame_sequencer.sv
tb/tb_serial_command_frame_sequencer.sv
